@@ design/rde_pkg.sv @@
// ----------------------------------------------------------------------------
// rde_pkg
// Types and constants shared by the relocation delta encoder modules.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_TYPE_MASK   = 2'd0;
  localparam logic [1:0] CFG_LONG_UPPER  = 2'd1;
  localparam logic [1:0] CFG_TYPE_LIMIT  = 2'd2;

  // Register reset values
  localparam logic [15:0] TYPE_MASK_RST  = 16'd7;
  localparam logic [15:0] LONG_UPPER_RST = 16'd5;
  localparam logic [15:0] TYPE_LIMIT_RST = 16'd3;

  // Byte step per relocation word
  localparam logic [31:0] WORD_STEP = 32'd2;

  typedef struct packed {
    logic [15:0] rel_word;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [24:0] fill_ones;
    logic        last;
  } out_item_t;

  // What the back end has to emit for one queued request
  typedef enum logic [1:0] {
    JOB_FIRST = 2'd0,  // absolute position, four bytes
    JOB_DELTA = 2'd1,  // gap to previous relocation, value holds gap minus one
    JOB_END   = 2'd2   // terminating zero byte
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        zero_gap;
    logic [31:0] value;
  } job_t;

endpackage

@@ design/rde_fifo.sv @@
// ----------------------------------------------------------------------------
// rde_fifo
// Small register queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module rde_fifo #(
  parameter int DATA_W = 35,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == FullCnt);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/rde_front.sv @@
// ----------------------------------------------------------------------------
// rde_front
// Accepts relocation words, tracks stream position and queues relocations.
// ----------------------------------------------------------------------------
module rde_front
  import rde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        accept_i,
  input  in_item_t    item_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [15:0] type_mask_q, long_upper_q, type_limit_q;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [31:0] prev_pos_q, prev_pos_d;
  logic [31:0] upper_pos_q, upper_pos_d;
  logic        have_prev_q, have_prev_d;
  logic        pending_q, pending_d;
  logic [15:0] kind;

  assign kind = (item_i.rel_word - 16'd1) & type_mask_q;

  // Classify the accepted word and update stream state
  always_comb begin
    byte_pos_d  = byte_pos_q;
    prev_pos_d  = prev_pos_q;
    upper_pos_d = upper_pos_q;
    have_prev_d = have_prev_q;
    pending_d   = pending_q;
    push_o      = 1'b0;
    job_o.kind     = JOB_END;
    job_o.zero_gap = 1'b0;
    job_o.value    = upper_pos_q;
    if (accept_i) begin
      priority if (item_i.end_of_stream) begin
        push_o      = 1'b1;
        byte_pos_d  = '0;
        prev_pos_d  = '0;
        upper_pos_d = '0;
        have_prev_d = 1'b0;
        pending_d   = 1'b0;
      end else if (pending_q) begin
        pending_d  = 1'b0;
        byte_pos_d = byte_pos_q + WORD_STEP;
        if (kind < type_limit_q) begin
          push_o      = 1'b1;
          prev_pos_d  = upper_pos_q;
          have_prev_d = 1'b1;
          if (!have_prev_q) begin
            job_o.kind = JOB_FIRST;
          end else begin
            // gap minus one: pos - prev - 1 == pos + ~prev
            job_o.kind     = JOB_DELTA;
            job_o.zero_gap = (upper_pos_q == prev_pos_q);
            job_o.value    = upper_pos_q + ~prev_pos_q;
          end
        end
      end else begin
        byte_pos_d = byte_pos_q + WORD_STEP;
        if ((item_i.rel_word & type_mask_q) == long_upper_q) begin
          upper_pos_d = byte_pos_q;
          pending_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_mask_q  <= TYPE_MASK_RST;
      long_upper_q <= LONG_UPPER_RST;
      type_limit_q <= TYPE_LIMIT_RST;
      byte_pos_q   <= '0;
      prev_pos_q   <= '0;
      upper_pos_q  <= '0;
      have_prev_q  <= 1'b0;
      pending_q    <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      prev_pos_q  <= prev_pos_d;
      upper_pos_q <= upper_pos_d;
      have_prev_q <= have_prev_d;
      pending_q   <= pending_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TYPE_MASK:  type_mask_q  <= cfg_data_i;
          CFG_LONG_UPPER: long_upper_q <= cfg_data_i;
          CFG_TYPE_LIMIT: type_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/rde_back.sv @@
// ----------------------------------------------------------------------------
// rde_back
// Splits gaps into filler count and remainder, and emits the table bytes.
// ----------------------------------------------------------------------------
module rde_back
  import rde_pkg::*;
#(
  parameter int MAX_GAP = 254
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_avail_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Reciprocal of the gap limit, scaled by 2^40; the quotient estimate is
  // at most one low for any 32-bit dividend
  localparam int          RecipShift = 40;
  localparam logic [40:0] RecipM = 41'((64'd1 << RecipShift) / 64'(MAX_GAP));
  localparam logic [19:0] RecipLo = RecipM[19:0];
  localparam logic [20:0] RecipHi = RecipM[40:20];
  localparam logic [7:0]  Gap = 8'(MAX_GAP);

  logic en;

  // Stage 1: partial products
  logic        s1_valid_q;
  job_t        s1_job_q;
  logic [51:0] s1_pp_lo_q;
  logic [52:0] s1_pp_hi_q;

  // Stage 2: quotient estimate
  logic        s2_valid_q;
  job_t        s2_job_q;
  logic [31:0] s2_qest_q;
  logic [72:0] s2_prod;

  // Stage 3: estimate times gap limit
  logic        s3_valid_q;
  job_t        s3_job_q;
  logic [31:0] s3_qest_q;
  logic [31:0] s3_qd_q;
  logic [39:0] s3_qd;

  // Emitter
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic [1:0]  byte_idx_q;
  logic        load_ok;
  logic        s3_done;
  logic [31:0] rem_raw;
  logic [8:0]  rem_corr;
  logic [31:0] quot;
  logic [7:0]  pos_byte;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign s3_done = s3_valid_q && load_ok &&
                   ((s3_job_q.kind != JOB_FIRST) || (byte_idx_q == 2'd3));
  assign en      = !s3_valid_q || s3_done;
  assign pop_o   = en && job_avail_i;

  assign s2_prod = 73'(s1_pp_lo_q) + (73'(s1_pp_hi_q) << 20);
  assign s3_qd   = 40'(s2_qest_q) * 40'(Gap);

  // Correct the estimate with one compare and subtract
  always_comb begin
    rem_raw = s3_job_q.value - s3_qd_q;
    if (rem_raw[8:0] >= {1'b0, Gap}) begin
      rem_corr = rem_raw[8:0] - {1'b0, Gap};
      quot     = s3_qest_q + 32'd1;
    end else begin
      rem_corr = rem_raw[8:0];
      quot     = s3_qest_q;
    end
  end

  // Pick the position byte, most significant first
  always_comb begin
    unique case (byte_idx_q)
      2'd0:    pos_byte = s3_job_q.value[31:24];
      2'd1:    pos_byte = s3_job_q.value[23:16];
      2'd2:    pos_byte = s3_job_q.value[15:8];
      default: pos_byte = s3_job_q.value[7:0];
    endcase
  end

  // Form the next result
  always_comb begin
    out_item_d.out_byte  = 8'd0;
    out_item_d.fill_ones = '0;
    out_item_d.last      = 1'b1;
    unique case (s3_job_q.kind)
      JOB_FIRST: begin
        out_item_d.out_byte = pos_byte;
        out_item_d.last     = (byte_idx_q == 2'd3);
      end
      JOB_DELTA: begin
        if (!s3_job_q.zero_gap) begin
          out_item_d.out_byte  = rem_corr[7:0] + 8'd1;
          out_item_d.fill_ones = quot[24:0];
        end
      end
      default: ;
    endcase
  end

  // Advance the divide pipeline as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= job_avail_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_job_q   <= job_i;
      s1_pp_lo_q <= 52'(job_i.value) * 52'(RecipLo);
      s1_pp_hi_q <= 53'(job_i.value) * 53'(RecipHi);
      s2_job_q   <= s1_job_q;
      s2_qest_q  <= s2_prod[71:40];
      s3_job_q   <= s2_job_q;
      s3_qest_q  <= s2_qest_q;
      s3_qd_q    <= s3_qd[31:0];
    end
  end

  // Hold the result until taken; step through position bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      byte_idx_q  <= 2'd0;
    end else if (load_ok) begin
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        byte_idx_q <= s3_done ? 2'd0 : byte_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && s3_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ design/relocation_delta_encoder.sv @@
// ----------------------------------------------------------------------------
// relocation_delta_encoder
// Encodes a stream of relocation words into a delta relocation table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one relocation
//   word or an end marker per request. Output channel out_valid_o /
//   out_stall_i / out_item_o carries table bytes, each with its count of
//   0x01 filler bytes. A request moves when valid is high and stall is low.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; an index beyond the list is ignored.
//   The front end takes one request per cycle while its queue has room and
//   keeps the stream position. The back end splits each gap by MAX_GAP with
//   a reciprocal multiply over three pipeline stages, then the output
//   register. Sustained rate is one request per cycle while the receiver
//   does not stall; only the first relocation of a stream holds the output
//   for one result per position byte. Reset clears the stream state, the
//   queue and the pipeline and loads the register defaults. When the
//   receiver stalls, the output holds, the queue fills and in_stall_o rises
//   once it is full.
// ----------------------------------------------------------------------------
module relocation_delta_encoder
  import rde_pkg::*;
#(
  parameter int MAX_GAP     = 254,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int JobW = $bits(job_t);

  logic            accept;
  logic            push;
  job_t            push_job;
  logic            pop;
  logic [JobW-1:0] pop_data;
  logic            q_empty;
  logic            q_full;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  rde_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .push_o     (push),
    .job_o      (push_job)
  );

  rde_fifo #(
    .DATA_W (JobW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  rde_back #(
    .MAX_GAP (MAX_GAP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!q_empty),
    .job_i       (job_t'(pop_data)),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives relocation words and end markers into the relocation delta encoder
// under random idling on both channels. A table of directed requests runs
// first, followed by long position gaps and random streams across several
// register settings. Every result is checked against the directed table or
// an in-bench model of the table encoding.
// ----------------------------------------------------------------------------
module testbench
  import rde_pkg::*;
();

  localparam int          GAP_STEP    = 254;
  localparam int          DRAIN_WAIT  = 12;
  localparam int          HOLD_CYCLES = 120;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;

  localparam out_item_t   NO_BYTE     = '0;

  typedef struct packed {
    in_item_t              item;
    logic                  typed;
    logic [2:0]            n_res;
    out_item_t [3:0]       res;
  } stim_row_t;

  // DUT signals
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_idx    = CFG_TYPE_MASK;
  logic [15:0] cfg_data   = 16'd0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  in_item_t    in_item    = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  out_item_t   out_item;

  // Model of the register file
  logic [15:0] mask_r  = TYPE_MASK_RST;
  logic [15:0] luc_r   = LONG_UPPER_RST;
  logic [15:0] limit_r = TYPE_LIMIT_RST;

  // Model of the stream state
  logic [31:0] byte_pos   = '0;
  logic [31:0] prev_pos   = '0;
  logic        have_prev  = 1'b0;
  logic        pend_upper = 1'b0;
  logic [31:0] upper_pos  = '0;

  // Bytes produced by the model for the last request
  out_item_t   enc_bytes [4];
  int          enc_count;

  // Table bytes still owed by the block, oldest first
  out_item_t   table_bytes_due [$];
  stim_row_t   dir_tab [$];

  int          mismatches = 0;
  int          cycles     = 0;
  bit          hold_req   = 1'b0;
  bit          calm       = 1'b0;
  int          stall_left = 0;
  int          rcv_roll;
  out_item_t   due_byte;

  relocation_delta_encoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t word_in(logic [15:0] w);
    return in_item_t'({w, 1'b0});
  endfunction

  function automatic in_item_t end_in(logic [15:0] w);
    return in_item_t'({w, 1'b1});
  endfunction

  function automatic out_item_t tbyte(logic [7:0] b, logic l);
    return out_item_t'({b, 25'd0, l});
  endfunction

  function automatic stim_row_t trow(in_item_t it, int n, out_item_t r0, out_item_t r1,
                                     out_item_t r2, out_item_t r3);
    stim_row_t row;
    row.item  = it;
    row.typed = 1'b1;
    row.n_res = n[2:0];
    row.res   = {r3, r2, r1, r0};
    return row;
  endfunction

  function automatic stim_row_t prow(in_item_t it);
    stim_row_t row;
    row       = '0;
    row.item  = it;
    return row;
  endfunction

  // Encode one request into table bytes and advance the stream state
  task automatic encode_reloc_word(input in_item_t it);
    logic [15:0] kind;
    logic [31:0] gap;
    logic [31:0] fill;
    logic [31:0] rest;
    enc_count = 0;
    if (it.end_of_stream) begin
      enc_bytes[0] = tbyte(8'd0, 1'b1);
      enc_count    = 1;
      byte_pos     = '0;
      prev_pos     = '0;
      have_prev    = 1'b0;
      pend_upper   = 1'b0;
      upper_pos    = '0;
      return;
    end
    if (pend_upper) begin
      kind       = (it.rel_word - 16'd1) & mask_r;
      pend_upper = 1'b0;
      if (kind < limit_r) begin
        if (!have_prev) begin
          enc_bytes[0] = tbyte(upper_pos[31:24], 1'b0);
          enc_bytes[1] = tbyte(upper_pos[23:16], 1'b0);
          enc_bytes[2] = tbyte(upper_pos[15:8], 1'b0);
          enc_bytes[3] = tbyte(upper_pos[7:0], 1'b1);
          enc_count    = 4;
        end else begin
          gap  = upper_pos - prev_pos;
          fill = '0;
          rest = '0;
          if (gap != 0) begin
            fill = (gap - 32'd1) / GAP_STEP;
            rest = gap - fill * GAP_STEP;
          end
          enc_bytes[0] = out_item_t'({rest[7:0], fill[24:0], 1'b1});
          enc_count    = 1;
        end
        prev_pos  = upper_pos;
        have_prev = 1'b1;
      end
    end else if ((it.rel_word & mask_r) == luc_r) begin
      upper_pos  = byte_pos;
      pend_upper = 1'b1;
    end
    byte_pos = byte_pos + WORD_STEP;
  endtask

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one request, wait for it to be taken, then queue its bytes
  task automatic send(input stim_row_t row);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= row.item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_reloc_word(row.item);
    if (row.typed) begin
      for (int i = 0; i < row.n_res; i++) table_bytes_due.push_back(row.res[i]);
    end else begin
      for (int i = 0; i < enc_count; i++) table_bytes_due.push_back(enc_bytes[i]);
    end
  endtask

  // Drop valid and hold until every owed byte has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (table_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_TYPE_MASK:  mask_r  = data;
      CFG_LONG_UPPER: luc_r   = data;
      CFG_TYPE_LIMIT: limit_r = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] mask, input logic [15:0] luc,
                           input logic [15:0] limit);
    wait_drained();
    write_reg(CFG_TYPE_MASK, mask);
    write_reg(CFG_LONG_UPPER, luc);
    write_reg(CFG_TYPE_LIMIT, limit);
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic bit marker_possible();
    return (luc_r & ~mask_r) == 16'd0;
  endfunction

  function automatic logic [15:0] marker_word();
    return (16'($urandom) & ~mask_r) | luc_r;
  endfunction

  // Pick a word that is not a marker, where the settings allow one
  function automatic logic [15:0] noise_word();
    logic [15:0] w;
    w = 16'($urandom);
    for (int t = 0; t < 8 && (w & mask_r) == luc_r; t++) w = 16'($urandom);
    return w;
  endfunction

  // Type word that mostly decodes below the limit
  function automatic logic [15:0] type_word();
    logic [15:0] k;
    if (limit_r == 16'd0 || $urandom_range(0, 9) < 3) return 16'($urandom);
    k = 16'($urandom_range(0, limit_r - 1));
    return ((k & mask_r) | (16'($urandom) & ~mask_r)) + 16'd1;
  endfunction

  // Advance n non-marker words, then send a marker and a type word
  task automatic spaced_pair(input int n);
    repeat (n) send(prow(word_in(noise_word())));
    send(prow(word_in(marker_word())));
    send(prow(word_in(type_word() | 16'd0)));
  endtask

  // Random streams: mostly marker and type pairs, some noise and end items
  task automatic random_items(input int count);
    int sent;
    int r;
    sent = 0;
    while (sent < count) begin
      calm = (sent >= count / 3) && (sent < count / 3 + 12);
      r = $urandom_range(0, 99);
      if (r < 55 && marker_possible()) begin
        send(prow(word_in(marker_word())));
        send(prow(word_in(type_word())));
        sent += 2;
      end else if (r < 85) begin
        send(prow(word_in(noise_word())));
        sent++;
      end else if (r < 92) begin
        send(prow(end_in(16'($urandom))));
        sent++;
      end else begin
        send(prow(word_in(16'($urandom))));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Receiver: check each taken result, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (table_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected byte %h fill %0d last %b",
                   out_item.out_byte, out_item.fill_ones, out_item.last);
      end else begin
        due_byte = table_bytes_due.pop_front();
        if (out_item.out_byte !== due_byte.out_byte ||
            out_item.fill_ones !== due_byte.fill_ones ||
            out_item.last !== due_byte.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h fill %0d last %b, got byte %h fill %0d last %b",
                     due_byte.out_byte, due_byte.fill_ones, due_byte.last,
                     out_item.out_byte, out_item.fill_ones, out_item.last);
        end
      end
    end
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    rcv_roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if (calm || rcv_roll < 70) begin
      out_stall <= 1'b0;
    end else if (rcv_roll < 95) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(8, 40);
    end
  end

  // Sequence of phases
  initial begin
    // Directed requests under reset settings: mask 7, marker 5, limit 3
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0001), 4, NO_BYTE, NO_BYTE, NO_BYTE,
                           tbyte(8'h00, 1'b1)));
    dir_tab.push_back(trow(end_in(16'h0000), 1, tbyte(8'h00, 1'b1), NO_BYTE, NO_BYTE,
                           NO_BYTE));
    dir_tab.push_back(trow(word_in(16'hFFFF), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'hFFFD), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    // type word 0 wraps to a type above the limit
    dir_tab.push_back(trow(word_in(16'h0000), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0003), 4, NO_BYTE, NO_BYTE, NO_BYTE,
                           tbyte(8'h06, 1'b1)));
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    // type equal to the limit relocates nothing
    dir_tab.push_back(trow(word_in(16'h0004), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h8001), 1, tbyte(8'h08, 1'b1), NO_BYTE, NO_BYTE,
                           NO_BYTE));
    // end item ignores its word
    dir_tab.push_back(trow(end_in(16'hFFFF), 1, tbyte(8'h00, 1'b1), NO_BYTE, NO_BYTE,
                           NO_BYTE));
    // end item drops a marker still waiting for its type word
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(end_in(16'h0000), 1, tbyte(8'h00, 1'b1), NO_BYTE, NO_BYTE,
                           NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0002), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    // a marker-looking word in the type slot is only a type
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0005), 0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
    dir_tab.push_back(trow(word_in(16'h0002), 4, NO_BYTE, NO_BYTE, NO_BYTE,
                           tbyte(8'h06, 1'b1)));
    dir_tab.push_back(prow(word_in(16'h7FFD)));
    dir_tab.push_back(prow(word_in(16'h0001)));
    dir_tab.push_back(prow(end_in(16'h5A5A)));

    // Reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send(dir_tab[i]);

    // Gap of one step plus two, where the first filler byte appears
    send(prow(end_in(16'h0000)));
    spaced_pair(0);
    spaced_pair(126);

    // Long receiver hold-off while relocating requests keep coming
    hold_req = 1'b1;
    repeat (12) begin
      send(prow(word_in(marker_word())));
      send(prow(word_in(16'h0001)));
    end
    random_items(8);

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_items(8);

    // Every word a marker, every type below the limit
    configure(16'h0000, 16'h0000, 16'h0001);
    random_items(5);
    wait_drained();
    random_items(5);

    // Limit zero: nothing is ever relocated
    configure(16'h00F0, 16'h0030, 16'h0000);
    random_items(8);

    configure(16'h000F, 16'h0009, 16'h0008);
    random_items(8);

    configure(16'($urandom) | 16'h0003, 16'($urandom_range(0, 3)),
              16'($urandom));
    random_items(8);

    wait_drained();
    if (table_bytes_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
